>>> rtl/cpr_pkg.sv
// ============================================================================
// cpr_pkg: shared constants and types for the clock page replacement block
// Field widths, parameter defaults and the controller state encoding.
// ============================================================================
`default_nettype none

package cpr_pkg;

    // Parameter defaults
    localparam int CPR_MAX_FRAMES = 16;
    localparam int CPR_PAGE_BITS  = 16;

    // Fixed field widths of the ports
    localparam int PAGE_FIELD_W  = 16;
    localparam int SLOT_FIELD_W  = 4;
    localparam int CFG_W         = 5;
    localparam int FAULT_W       = 32;

    // Reset value of the frame count register
    localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = 5'd16;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SWEEP,
        S_EVICT
    } t_state;

endpackage : cpr_pkg

`default_nettype wire

>>> rtl/cpr_page_mem.sv
// ============================================================================
// cpr_page_mem: resident page store
// One write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module cpr_page_mem
    import cpr_pkg::*;
#(
    parameter int DEPTH = CPR_MAX_FRAMES,
    parameter int WIDTH = CPR_PAGE_BITS,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : cpr_page_mem

`default_nettype wire

>>> rtl/clock_page_replacement.sv
// ============================================================================
// clock_page_replacement: clock (second chance) page replacement engine
// Page numbers live in a one-port-read memory that is scanned per request;
// valid and use bits are flops, so reset and a start with i_start_req clear them at once.
// ============================================================================
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  request   | start / busy         | i_page, i_start_req
//  result    | o_valid (1 cycle)    | o_hit, o_frame_slot, o_evicted_valid,
//            |                      | o_evicted_page, o_fault_total
//  config    | i_cfg_we             | i_cfg_data (frames in use)
//
//  With n active frames, a hit in frame k ends the scan at that frame; a miss
//  scans all n frames, then sweeps, clearing set use bits until the hand
//  finds a clear one, then evicts that frame and raises o_valid.
//  The scan is bound by the single read port of the page memory, which is
//  read once per frame in index order.
//  Reset: synchronous, active low; clears valid/use bits, hand, fault count
//  and the frame count register (16). No memory clearing pass is needed.
//  busy is high from the accept edge until the result strobe; the result
//  cannot be stalled, and a new request may be taken in the strobe cycle.
// ============================================================================
`default_nettype none

module clock_page_replacement
    import cpr_pkg::*;
#(
    parameter int MAX_FRAMES = CPR_MAX_FRAMES,
    parameter int PAGE_BITS  = CPR_PAGE_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // request
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [PAGE_FIELD_W-1:0] i_page,
    input  wire logic                    i_start_req,
    // configuration
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_W-1:0]        i_cfg_data,
    // result
    output logic                         o_valid,
    output logic                         o_hit,
    output logic [SLOT_FIELD_W-1:0]      o_frame_slot,
    output logic                         o_evicted_valid,
    output logic [PAGE_FIELD_W-1:0]      o_evicted_page,
    output logic [FAULT_W-1:0]           o_fault_total
);

    // Index width, count width (holds MAX_FRAMES), compare width vs config
    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NW = IW + 1;
    localparam int WW = (NW > CFG_W) ? NW : CFG_W;

    t_state r_state, n_state;

    logic [CFG_W-1:0]     r_frames;
    logic [PAGE_BITS-1:0] r_page;
    logic [MAX_FRAMES-1:0] r_valid;
    logic [MAX_FRAMES-1:0] r_use;
    logic [IW-1:0]        r_hand;
    logic [FAULT_W-1:0]   r_fault;
    logic [NW-1:0]        r_idx;      // next frame to read during scan
    logic                 r_cmp_vld;  // read data of r_cmp_idx is on rd_data
    logic [IW-1:0]        r_cmp_idx;

    logic                    r_out_vld;
    logic                    r_out_hit;
    logic [SLOT_FIELD_W-1:0] r_out_slot;
    logic                    r_out_ev_vld;
    logic [PAGE_FIELD_W-1:0] r_out_ev_page;

    // Active frame count: 0 acts as 1, above MAX_FRAMES clamps
    logic [WW-1:0] cfg_w;
    logic [WW-1:0] n_w;
    logic [NW-1:0] act_n;

    always_comb begin
        cfg_w = WW'(r_frames);
        if (cfg_w == '0) begin
            n_w = WW'(1);
        end else if (cfg_w > WW'(MAX_FRAMES)) begin
            n_w = WW'(MAX_FRAMES);
        end else begin
            n_w = cfg_w;
        end
    end
    assign act_n = NW'(n_w);

    // Page memory
    logic                 mem_re;
    logic [IW-1:0]        mem_raddr;
    logic                 mem_we;
    logic [PAGE_BITS-1:0] rd_data;

    cpr_page_mem #(
        .DEPTH (MAX_FRAMES),
        .WIDTH (PAGE_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_hand),
        .i_wdata (r_page),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    // Scan status
    logic          accept;
    logic          hit_now;
    logic          scan_done;
    logic          idx_live;
    logic [NW-1:0] hand_inc;
    logic [IW-1:0] hand_next;

    assign accept    = start && !busy;
    assign idx_live  = (r_idx < act_n);
    assign hit_now   = r_cmp_vld && r_valid[r_cmp_idx] && (rd_data == r_page);
    assign scan_done = !idx_live && !r_cmp_vld;
    assign hand_inc  = NW'({1'b0, r_hand}) + NW'(1);
    assign hand_next = (hand_inc >= act_n) ? '0 : IW'(hand_inc);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (hit_now) begin
                    n_state = S_IDLE;
                end else if (scan_done) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (!r_use[r_hand]) n_state = S_EVICT;
            end
            S_EVICT: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        busy      = 1'b1;
        mem_re    = 1'b0;
        mem_raddr = r_hand;
        mem_we    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
            end
            S_SCAN: begin
                mem_re    = idx_live;
                mem_raddr = IW'(r_idx);
            end
            S_SWEEP: begin
                // fetch the victim's page for the eviction report
                mem_re = !r_use[r_hand];
            end
            S_EVICT: begin
                mem_we = 1'b1;
            end
            default: busy = 1'b1;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_frames  <= CFG_FRAMES_RESET;
            r_valid   <= '0;
            r_use     <= '0;
            r_hand    <= '0;
            r_fault   <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            // strobe on a scan hit or at the end of an eviction
            r_out_vld <= ((r_state == S_SCAN) && hit_now) || (r_state == S_EVICT);
            if (i_cfg_we) begin
                r_frames <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cmp_vld <= 1'b0;
                    if (accept) begin
                        if (i_start_req) begin
                            r_valid <= '0;
                            r_use   <= '0;
                            r_fault <= '0;
                            r_hand  <= '0;
                        end else if (NW'({1'b0, r_hand}) >= act_n) begin
                            // frame count shrank under the hand
                            r_hand <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    r_cmp_vld <= idx_live;
                    if (hit_now) begin
                        r_use[r_cmp_idx] <= 1'b1;
                    end
                end
                S_SWEEP: begin
                    if (r_use[r_hand]) begin
                        r_use[r_hand] <= 1'b0;
                        r_hand        <= hand_next;
                    end
                end
                S_EVICT: begin
                    r_valid[r_hand] <= 1'b1;
                    r_use[r_hand]   <= 1'b1;
                    r_hand          <= hand_next;
                    if (r_fault != '1) begin
                        r_fault <= r_fault + FAULT_W'(1);
                    end
                end
                default: r_cmp_vld <= 1'b0;
            endcase
        end
    end

    // Datapath (no reset)
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page <= PAGE_BITS'(i_page);
            r_idx  <= '0;
        end else if (r_state == S_SCAN && idx_live) begin
            r_idx     <= r_idx + NW'(1);
            r_cmp_idx <= IW'(r_idx);
        end
        if (r_state == S_SCAN && hit_now) begin
            r_out_hit     <= 1'b1;
            r_out_slot    <= SLOT_FIELD_W'(r_cmp_idx);
            r_out_ev_vld  <= 1'b0;
            r_out_ev_page <= '0;
        end else if (r_state == S_EVICT) begin
            r_out_hit     <= 1'b0;
            r_out_slot    <= SLOT_FIELD_W'(r_hand);
            r_out_ev_vld  <= r_valid[r_hand];
            r_out_ev_page <= r_valid[r_hand] ? PAGE_FIELD_W'(rd_data) : '0;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_hit           = r_out_hit;
    assign o_frame_slot    = r_out_slot;
    assign o_evicted_valid = r_out_ev_vld;
    assign o_evicted_page  = r_out_ev_page;
    assign o_fault_total   = r_fault;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request accept");

    a_miss_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_fault_total != '0))
        else $error("fault reported with zero fault count");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (!o_evicted_valid && (o_evicted_page == '0)))
        else $error("hit reported an eviction");

    a_evict_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVICT) |=> (o_valid && r_valid[$past(r_hand)]))
        else $error("evict cycle did not fill the victim frame");

endmodule : clock_page_replacement

`default_nettype wire
